FILE: rtl/rlse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_pkg: shared types and constants of the LED strip effect engine
// Field widths, register indexes, reset values and the queue entry format.
// ----------------------------------------------------------------------------
package rlse_pkg;

	localparam int unsigned FIRST_W     = 6;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned COLOR_W     = 24;
	localparam int unsigned INDEX_W     = 6;
	localparam int unsigned POS_W       = 7;
	localparam int unsigned DOT_W       = 8;
	localparam int unsigned TICK_W      = 3;
	localparam int unsigned LEVEL_W     = 8;
	localparam int unsigned DIV_BITS    = DOT_W + 1;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 6;

	localparam int unsigned DEF_STRIP_LEDS = 64;
	localparam int unsigned DEF_SEGMENTS   = 2;

	localparam logic [COUNT_W-1:0] MAX_SEG_LEDS     = 5'd16;
	localparam logic [TICK_W-1:0]  DOT_ADVANCE_TICK = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP        = 8'hFF;

	typedef enum logic [1:0] {
		MODE_STEADY = 2'd0,
		MODE_DOT    = 2'd1,
		MODE_BREATH = 2'd2,
		MODE_BLINK  = 2'd3
	} mode_t;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_SEG0_FIRST = 2'd0;
	localparam cfg_index_t REG_SEG0_COUNT = 2'd1;
	localparam cfg_index_t REG_SEG1_FIRST = 2'd2;
	localparam cfg_index_t REG_SEG1_COUNT = 2'd3;

	localparam logic [FIRST_W-1:0] SEG0_FIRST_RST = 6'd0;
	localparam logic [COUNT_W-1:0] SEG0_COUNT_RST = 5'd8;
	localparam logic [FIRST_W-1:0] SEG1_FIRST_RST = 6'd8;
	localparam logic [COUNT_W-1:0] SEG1_COUNT_RST = 5'd8;

	// One classified effect tick, as it waits between front and back.
	typedef struct packed {
		logic               seg;
		mode_t              mode;
		logic [COLOR_W-1:0] color;
		logic [FIRST_W-1:0] first;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage
`default_nettype wire

FILE: rtl/rlse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_front: configuration registers and tick classification
// Takes ticks in, attaches the segment geometry and pushes them to the queue.
// ----------------------------------------------------------------------------
module rlse_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rlse_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rlse_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          segment,
	input  wire logic [1:0]                    mode,
	input  wire logic [rlse_pkg::COLOR_W-1:0]  base_color,
	input  wire logic                          q_full,
	output logic                               push,
	output rlse_pkg::entry_t                   push_entry
);
	import rlse_pkg::*;

	logic [FIRST_W-1:0] seg0_first_q, seg1_first_q, first_sel;
	logic [COUNT_W-1:0] seg0_count_q, seg1_count_q, count_sel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg0_first_q <= SEG0_FIRST_RST;
			seg0_count_q <= SEG0_COUNT_RST;
			seg1_first_q <= SEG1_FIRST_RST;
			seg1_count_q <= SEG1_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEG0_FIRST: seg0_first_q <= cfg_data[FIRST_W-1:0];
				REG_SEG0_COUNT: seg0_count_q <= cfg_data[COUNT_W-1:0];
				REG_SEG1_FIRST: seg1_first_q <= cfg_data[FIRST_W-1:0];
				REG_SEG1_COUNT: seg1_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign first_sel = segment ? seg1_first_q : seg0_first_q;
	assign count_sel = segment ? seg1_count_q : seg0_count_q;

	// A segment longer than the engine handles is cut down to the maximum.
	always_comb begin
		push_entry.seg   = segment;
		push_entry.mode  = mode_t'(mode);
		push_entry.color = base_color;
		push_entry.first = first_sel;
		push_entry.count = (count_sel > MAX_SEG_LEDS) ? MAX_SEG_LEDS : count_sel;
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

endmodule
`default_nettype wire

FILE: rtl/rlse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_queue: short queue between the front and the back
// Holds classified ticks so that either side can stall on its own.
// ----------------------------------------------------------------------------
module rlse_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  rlse_pkg::entry_t      push_entry,
	output logic                  full,
	input  wire logic             pop,
	output rlse_pkg::entry_t      head,
	output logic                  head_valid
);
	import rlse_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	entry_t            slots [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head       = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue occupancy beyond its depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

FILE: rtl/rlse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlse_back: effect state and per-LED result generation
// Applies one tick to its segment's state and emits one result per LED.
// ----------------------------------------------------------------------------
module rlse_back #(
	parameter int unsigned STRIP_LEDS = rlse_pkg::DEF_STRIP_LEDS,
	parameter int unsigned SEGMENTS   = rlse_pkg::DEF_SEGMENTS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  rlse_pkg::entry_t                   head,
	input  wire logic                          head_valid,
	output logic                               pop,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [rlse_pkg::INDEX_W-1:0]       led_index,
	output logic [rlse_pkg::COLOR_W-1:0]       led_color,
	output logic                               last_led
);
	import rlse_pkg::*;

	localparam int unsigned IDX_W  = $clog2(STRIP_LEDS);
	localparam int unsigned ST_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int unsigned DCNT_W = $clog2(DIV_BITS);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(STRIP_LEDS - 1);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_BITS - 1);

	// Strip position of each possible first LED, wrapped to the strip length.
	typedef logic [IDX_W-1:0] mod_tab_t [2**FIRST_W];

	function automatic mod_tab_t build_mod_tab();
		mod_tab_t tab;
		for (int i = 0; i < 2**FIRST_W; i++) begin
			tab[i] = IDX_W'(i % STRIP_LEDS);
		end
		return tab;
	endfunction

	localparam mod_tab_t MOD_TAB = build_mod_tab();

	function automatic logic [7:0] dim_byte(input logic [7:0] b, input logic [7:0] lvl);
		return (b == 8'd0) ? 8'd0 : b - lvl;
	endfunction

	typedef enum logic [1:0] {
		B_IDLE,
		B_MOD,
		B_EMIT
	} bstate_t;

	bstate_t              state_q;
	logic                 result_valid_q;

	// Per-segment effect state.
	logic [DOT_W-1:0]     dot_q     [SEGMENTS];
	logic [TICK_W-1:0]    tick_q    [SEGMENTS];
	logic [LEVEL_W-1:0]   level_q   [SEGMENTS];
	logic                 rising_q  [SEGMENTS];
	logic                 blink_q   [SEGMENTS];

	// Job registers of the tick being carried out.
	logic [ST_W-1:0]      st_q;
	logic                 dot_mode_q;
	logic [COLOR_W-1:0]   color_q, shown_q;
	logic [DOT_W-1:0]     dotp_q;
	logic [COUNT_W-1:0]   count_q, k_q;
	logic [IDX_W-1:0]     idx_q;
	logic [POS_W-1:0]     pos_q, span_q, rem_q;
	logic [DIV_BITS-1:0]  div_n_q;
	logic [DCNT_W-1:0]    div_cnt_q;

	logic [INDEX_W-1:0]   led_index_q;
	logic [COLOR_W-1:0]   led_color_q;
	logic                 last_led_q;

	// Decode of the queue head.
	logic [ST_W-1:0]      st_in;
	logic [DOT_W-1:0]     dot_cur, dotp_in;
	logic [POS_W-1:0]     span_in;
	logic [LEVEL_W-1:0]   level_cur;
	logic                 rising_new;
	logic                 blink_new;
	logic                 advance;
	logic                 need_mod;
	logic [COLOR_W-1:0]   shown_in;

	logic                 emit_go;
	logic                 last_k;
	logic [POS_W:0]       trial;
	logic                 trial_ge;
	logic [POS_W-1:0]     rem_next;

	always_comb begin
		st_in     = (SEGMENTS == 1) ? '0 : ST_W'(head.seg);
		dot_cur   = dot_q[st_in];
		dotp_in   = (dot_cur < DOT_W'(head.first)) ? DOT_W'(head.first) : dot_cur;
		span_in   = POS_W'(head.first) + POS_W'(head.count);
		level_cur = level_q[st_in];
		blink_new = ~blink_q[st_in];
		advance   = (tick_q[st_in] == DOT_ADVANCE_TICK);
		need_mod  = (head.mode == MODE_DOT) && advance && (span_in != '0);

		if (level_cur == LEVEL_TOP) begin
			rising_new = 1'b0;
		end else if (level_cur == '0) begin
			rising_new = 1'b1;
		end else begin
			rising_new = rising_q[st_in];
		end

		case (head.mode)
			MODE_BREATH: shown_in = {dim_byte(head.color[23:16], level_cur),
						 dim_byte(head.color[15:8], level_cur),
						 dim_byte(head.color[7:0], level_cur)};
			MODE_BLINK:  shown_in = blink_new ? head.color : '0;
			default:     shown_in = head.color;
		endcase
	end

	// One restoring remainder step per cycle for the running-dot wrap.
	always_comb begin
		trial    = {rem_q, div_n_q[DIV_BITS-1]};
		trial_ge = (trial >= {1'b0, span_q});
		rem_next = trial_ge ? POS_W'(trial - {1'b0, span_q}) : POS_W'(trial);
	end

	assign pop     = (state_q == B_IDLE) && head_valid;
	assign emit_go = (state_q == B_EMIT) && (!result_valid_q || !result_stall);
	assign last_k  = ((k_q + COUNT_W'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			result_valid_q <= 1'b0;
			for (int s = 0; s < SEGMENTS; s++) begin
				dot_q[s]    <= '0;
				tick_q[s]   <= '0;
				level_q[s]  <= '0;
				rising_q[s] <= 1'b0;
				blink_q[s]  <= 1'b0;
			end
		end else begin
			if (emit_go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				B_IDLE: begin
					if (head_valid) begin
						case (head.mode)
							MODE_DOT: begin
								if (advance && (span_in == '0)) begin
									dot_q[st_in] <= '0;
								end else begin
									dot_q[st_in] <= dotp_in;
								end
								tick_q[st_in] <= advance ? '0 : tick_q[st_in] + TICK_W'(1);
							end
							MODE_BREATH: begin
								rising_q[st_in] <= rising_new;
								level_q[st_in]  <= rising_new ? level_cur + LEVEL_W'(1)
											  : level_cur - LEVEL_W'(1);
							end
							MODE_BLINK: begin
								blink_q[st_in] <= blink_new;
							end
							default: ;
						endcase
						if (need_mod) begin
							state_q <= B_MOD;
						end else if (head.count != '0) begin
							state_q <= B_EMIT;
						end
					end
				end
				B_MOD: begin
					if (div_cnt_q == DCNT_LAST) begin
						dot_q[st_q] <= DOT_W'(rem_next);
						state_q     <= (count_q == '0) ? B_IDLE : B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit_go && last_k) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			st_q       <= st_in;
			dot_mode_q <= (head.mode == MODE_DOT);
			color_q    <= head.color;
			shown_q    <= shown_in;
			dotp_q     <= dotp_in;
			count_q    <= head.count;
			k_q        <= '0;
			idx_q      <= MOD_TAB[head.first];
			pos_q      <= POS_W'(head.first);
			span_q     <= span_in;
			rem_q      <= '0;
			div_n_q    <= DIV_BITS'(dotp_in) + DIV_BITS'(1);
			div_cnt_q  <= '0;
		end
		if (state_q == B_MOD) begin
			rem_q     <= rem_next;
			div_n_q   <= {div_n_q[DIV_BITS-2:0], 1'b0};
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
		if (emit_go) begin
			led_index_q <= INDEX_W'(idx_q);
			if (dot_mode_q) begin
				led_color_q <= (DOT_W'(pos_q) == dotp_q) ? color_q : '0;
			end else begin
				led_color_q <= shown_q;
			end
			last_led_q <= last_k;
			idx_q      <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
			pos_q      <= pos_q + POS_W'(1);
			k_q        <= k_q + COUNT_W'(1);
		end
	end

	assign result_valid = result_valid_q;
	assign led_index    = led_index_q;
	assign led_color    = led_color_q;
	assign last_led     = last_led_q;

`ifndef NO_ASSERTIONS
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q[0] <= DOT_ADVANCE_TICK)
		else $error("running-dot tick counter out of range");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (k_q < count_q))
		else $error("LED counter past the segment length");
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_k) |=> (state_q == B_IDLE))
		else $error("emission did not finish after the last LED");
	a_mod_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MOD) |-> (span_q != '0))
		else $error("remainder unit started with a zero span");
`endif

endmodule
`default_nettype wire

FILE: rtl/rgb_led_strip_effect_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_strip_effect_engine_unit: two-segment LED strip effect engine
// Turns effect ticks into one GRB colour result per LED of the segment.
// ----------------------------------------------------------------------------
// Path: a tick's first result passes the queue, the back end and its output
//   register; a running-dot advance first passes the remainder unit.
// Throughput: one LED result per cycle while result_stall is low; a tick
//   holds the back end for its LEDs, plus the remainder unit on a dot step.
// Reset: effect state clears to zero and the segment registers take their
//   defaults at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module rgb_led_strip_effect_engine_unit #(
	parameter int unsigned STRIP_LEDS = rlse_pkg::DEF_STRIP_LEDS,
	parameter int unsigned SEGMENTS   = rlse_pkg::DEF_SEGMENTS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rlse_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rlse_pkg::CFG_DATA_W-1:0]  cfg_data,
	// effect tick channel
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             segment,
	input  wire logic [1:0]                       mode,
	input  wire logic [rlse_pkg::COLOR_W-1:0]     base_color,
	// LED result channel
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic [rlse_pkg::INDEX_W-1:0]          led_index,
	output logic [rlse_pkg::COLOR_W-1:0]          led_color,
	output logic                                  last_led
);
	import rlse_pkg::*;

	// The front end owns the segment registers. Each tick transaction is
	// tagged with its segment's first LED and saturated LED count and then
	// written straight into the queue; the tick channel stalls only while
	// the queue is full.
	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   head_valid;

	rlse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.segment    (segment),
		.mode       (mode),
		.base_color (base_color),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// A two-entry queue lets the front keep taking ticks while the back end
	// is still working through the LEDs of an earlier one.
	rlse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// The back end applies one tick at a time to its segment's effect state.
	// The running-dot wrap is a remainder by the segment span, worked out
	// one bit per cycle before emission. Results then leave one LED per
	// cycle while result_stall is low, through an output register, so a
	// stalled last result does not block the next tick from being loaded.
	rlse_back #(
		.STRIP_LEDS (STRIP_LEDS),
		.SEGMENTS   (SEGMENTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_index    (led_index),
		.led_color    (led_color),
		.last_led     (last_led)
	);

endmodule
`default_nettype wire

FILE: sim/tb_rgb_led_strip_effect_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_effect_engine_unit: self-checking bench for the effect engine
// Drives effect ticks and segment layouts, predicts every LED colour from an
// internal copy of the per-segment effect state and checks each LED result
// in order, under random idling on both the tick and the result channel.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_effect_engine_unit;

	import rlse_pkg::*;

	// The running dot moves on every fifth dot tick of its segment.
	localparam int unsigned TICKS_PER_STEP = 5;
	// Cycles allowed after the last expected LED before the engine counts as
	// idle: a dot advance adds the remainder unit to the normal latency.
	localparam int unsigned SETTLE_CYCLES  = 24;
	localparam int unsigned DRAIN_LIMIT    = 20000;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [COLOR_W-1:0] colour;
		logic               last;
	} led_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   item_valid;
	logic                   item_stall;
	logic                   segment;
	logic [1:0]             mode;
	logic [COLOR_W-1:0]     base_color;
	logic                   result_valid;
	logic                   result_stall;
	logic [INDEX_W-1:0]     led_index;
	logic [COLOR_W-1:0]     led_color;
	logic                   last_led;

	// Segment layout as the engine should currently hold it.
	logic [FIRST_W-1:0] seg_first [2];
	logic [COUNT_W-1:0] seg_count [2];

	// Effect state of each segment, mirrored tick by tick.
	int unsigned        dot_pos    [2];
	int unsigned        dot_ticks  [2];
	logic [LEVEL_W-1:0] breath_lvl [2];
	logic               breath_up  [2];
	logic               blink_lit  [2];

	// LED colours still owed by the engine, oldest first.
	led_result_t pending_leds [$];

	// When set, neither side idles: the closing stretch runs at full rate.
	bit quiet;

	int unsigned fault_count;
	int unsigned ticks_sent;
	int unsigned leds_checked;
	int unsigned reg_writes;
	int unsigned breath_turns;
	int unsigned dot_steps;

	rgb_led_strip_effect_engine_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.segment      (segment),
		.mode         (mode),
		.base_color   (base_color),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_index    (led_index),
		.led_color    (led_color),
		.last_led     (last_led)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A hard ceiling on the run, far beyond the slowest legitimate run.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Breathing dims each nonzero byte by the current level, wrapping modulo
	// 256; a byte that is already zero stays dark.
	function automatic logic [7:0] dim_byte(input logic [7:0] b, input logic [7:0] lvl);
		return (b == 8'd0) ? 8'd0 : b - lvl;
	endfunction

	// Works out the LED colours of one accepted tick, queues them, and then
	// advances the effect state of the segment exactly as the engine should.
	task automatic paint_segment(input logic seg, input mode_t m,
			input logic [COLOR_W-1:0] colour);
		int unsigned        first;
		int unsigned        count;
		int unsigned        span;
		int unsigned        pos;
		logic [COLOR_W-1:0] shown;
		led_result_t        led;
		first = seg_first[seg];
		count = seg_count[seg];
		if (count > MAX_SEG_LEDS) begin
			count = MAX_SEG_LEDS;
		end
		shown = colour;
		case (m)
			MODE_DOT: begin
				// The dot never sits before the segment's first LED.
				if (dot_pos[seg] < first) begin
					dot_pos[seg] = first;
				end
			end
			MODE_BREATH: begin
				shown = {dim_byte(colour[23:16], breath_lvl[seg]),
					dim_byte(colour[15:8], breath_lvl[seg]),
					dim_byte(colour[7:0], breath_lvl[seg])};
			end
			MODE_BLINK: begin
				blink_lit[seg] = ~blink_lit[seg];
				shown = blink_lit[seg] ? colour : '0;
			end
			default: ;
		endcase
		for (int unsigned k = 0; k < count; k++) begin
			pos = first + k;
			// The strip index wraps, but the dot match uses the unwrapped position.
			led.index = pos[INDEX_W-1:0];
			if (m == MODE_DOT) begin
				led.colour = (pos == dot_pos[seg]) ? colour : '0;
			end else begin
				led.colour = shown;
			end
			led.last = (k + 1 == count);
			pending_leds.push_back(led);
		end
		if (m == MODE_DOT) begin
			span = first + count;
			if (dot_ticks[seg] == DOT_ADVANCE_TICK) begin
				dot_steps++;
				// An empty layout at the strip start parks the dot at zero.
				dot_pos[seg] = (span == 0) ? 0 : ((dot_pos[seg] + 1) % span) & 8'hFF;
			end
			dot_ticks[seg] = (dot_ticks[seg] + 1) % TICKS_PER_STEP;
		end else if (m == MODE_BREATH) begin
			if (breath_lvl[seg] == LEVEL_TOP) begin
				breath_up[seg] = 1'b0;
				breath_turns++;
			end else if (breath_lvl[seg] == 8'd0) begin
				breath_up[seg] = 1'b1;
			end
			breath_lvl[seg] = breath_up[seg] ? breath_lvl[seg] + 8'd1 : breath_lvl[seg] - 8'd1;
		end
	endtask

	// Offers one tick, possibly after a short gap, and waits for its
	// transaction. Valid is left high so that the next tick can follow at once.
	task automatic send_tick(input logic seg, input mode_t m, input logic [COLOR_W-1:0] colour);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid = 1'b1;
		segment    = seg;
		mode       = m;
		base_color = colour;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		paint_segment(seg, m, colour);
		ticks_sent++;
	endtask

	// Stops offering ticks and waits until every owed LED has arrived, then
	// lets the engine settle, so that it is certainly idle afterwards.
	task automatic drain_engine();
		int unsigned n;
		n = 0;
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_leds.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		// Only the low bits of each register are kept.
		case (idx)
			REG_SEG0_FIRST: seg_first[0] = value[FIRST_W-1:0];
			REG_SEG0_COUNT: seg_count[0] = value[COUNT_W-1:0];
			REG_SEG1_FIRST: seg_first[1] = value[FIRST_W-1:0];
			REG_SEG1_COUNT: seg_count[1] = value[COUNT_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Every layout change waits for an idle engine and writes all four registers.
	task automatic apply_layout(input logic [5:0] first0, input logic [5:0] count0,
			input logic [5:0] first1, input logic [5:0] count1);
		drain_engine();
		write_reg(REG_SEG0_FIRST, first0);
		write_reg(REG_SEG0_COUNT, count0);
		write_reg(REG_SEG1_FIRST, first1);
		write_reg(REG_SEG1_COUNT, count1);
	endtask

	function automatic logic [5:0] pick_first();
		case ($urandom_range(0, 3))
			0: return 6'd0;
			1: return 6'd63;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	// Mostly short segments keep the run quick; full and oversized ones still occur.
	function automatic logic [5:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 6'd0;
			1: return 6'd16;
			2: return 6'($urandom_range(0, 63));
			default: return 6'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic random_layout();
		apply_layout(pick_first(), pick_count(), pick_first(), pick_count());
	endtask

	// Colour bytes are often zero so that breathing sees dark bytes too.
	function automatic logic [COLOR_W-1:0] pick_colour();
		logic [COLOR_W-1:0] c;
		c = COLOR_W'($urandom);
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				c[i*8 +: 8] = 8'd0;
			end
		end
		return c;
	endfunction

	// Result stall comes in random bursts, with long free
	// stretches in between and none at all once the run turns quiet.
	initial begin : stall_gen
		int unsigned burst;
		burst = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				result_stall = 1'b1;
				burst--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall = 1'b1;
				burst = $urandom_range(1, 4) - 1;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	// Every LED transaction is matched against the oldest owed colour.
	always @(posedge clk) begin : check_leds
		led_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_leds.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected LED result index %0d colour %06h last %0b",
						$time, led_index, led_color, last_led);
				end
			end else begin
				want = pending_leds.pop_front();
				leds_checked++;
				if (led_index !== want.index || led_color !== want.colour ||
						last_led !== want.last) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("%0t: LED mismatch: expected index %0d colour %06h last %0b,",
							$time, want.index, want.colour, want.last);
						$display("    got index %0d colour %06h last %0b",
							led_index, led_color, last_led);
					end
				end
			end
		end
	end

	// Reset layout: full white on segment zero and black on segment one.
	task automatic test_default_layout();
		send_tick(1'b0, MODE_STEADY, 24'hFFFFFF);
		send_tick(1'b1, MODE_STEADY, 24'h000000);
	endtask

	// Each effect once or more: blink on then off, two breathing levels over a
	// colour with a dark byte, and enough dot ticks to clamp and then advance.
	task automatic test_each_effect();
		send_tick(1'b0, MODE_BLINK, 24'h12AB34);
		send_tick(1'b0, MODE_BLINK, 24'h12AB34);
		send_tick(1'b0, MODE_BREATH, 24'h00FF01);
		send_tick(1'b0, MODE_BREATH, 24'h00FF01);
		for (int i = 0; i < 6; i++) begin
			send_tick(1'b1, MODE_DOT, 24'hA5005A);
		end
	endtask

	// Layout corners: a segment running past the strip end, an empty segment
	// whose state still moves, the dot parked at zero when first and count are
	// both zero, and a count above the segment maximum being saturated.
	task automatic test_layout_extremes();
		apply_layout(6'd63, 6'd16, 6'd0, 6'd0);
		send_tick(1'b0, MODE_STEADY, 24'h5A5A5A);
		send_tick(1'b0, MODE_DOT, 24'hFFFFFF);
		send_tick(1'b1, MODE_STEADY, 24'h123456);
		send_tick(1'b1, MODE_BREATH, 24'h010101);
		for (int i = 0; i < TICKS_PER_STEP; i++) begin
			send_tick(1'b1, MODE_DOT, 24'h00FF00);
		end
		apply_layout(6'd5, 6'h3F, 6'd40, 6'd16);
		send_tick(1'b0, MODE_BLINK, 24'hC3C3C3);
		send_tick(1'b1, MODE_STEADY, 24'h800001);
	endtask

	// Runs of one effect on one segment get the dot round its segment and the
	// blink through both phases; single ticks of any kind are mixed in as noise.
	task automatic test_effect_runs(input int unsigned n_ticks);
		int unsigned sent;
		int unsigned since_layout;
		int unsigned len;
		logic        seg;
		mode_t       m;
		logic [COLOR_W-1:0] colour;
		sent = 0;
		since_layout = 0;
		random_layout();
		while (sent < n_ticks) begin
			seg = 1'($urandom_range(0, 1));
			m = mode_t'($urandom_range(0, 3));
			len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(5, 15);
			colour = pick_colour();
			for (int unsigned i = 0; i < len; i++) begin
				send_tick(seg, m, ($urandom_range(0, 2) == 0) ? pick_colour() : colour);
			end
			sent += len;
			since_layout += len;
			if (since_layout >= 40) begin
				random_layout();
				since_layout = 0;
			end
		end
	endtask

	// Mostly breathing on segment zero, enough to carry the level to the top
	// and turn it round; a pause halfway lets the engine empty completely.
	task automatic test_breath_sweep(input int unsigned n_ticks);
		apply_layout(pick_first(), 6'($urandom_range(1, 3)), pick_first(),
			6'($urandom_range(0, 2)));
		for (int unsigned i = 0; i < n_ticks; i++) begin
			if (i == n_ticks / 2) begin
				drain_engine();
			end
			if ($urandom_range(0, 9) != 0) begin
				send_tick(1'b0, MODE_BREATH, pick_colour());
			end else begin
				send_tick(1'($urandom_range(0, 1)), mode_t'($urandom_range(0, 3)),
					pick_colour());
			end
		end
	endtask

	// Back-to-back ticks with the result side never stalling.
	task automatic test_full_rate(input int unsigned n_ticks);
		random_layout();
		quiet = 1'b1;
		for (int unsigned i = 0; i < n_ticks; i++) begin
			send_tick(1'($urandom_range(0, 1)), mode_t'($urandom_range(0, 3)), pick_colour());
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		item_valid = 1'b0;
		segment    = 1'b0;
		mode       = '0;
		base_color = '0;
		quiet      = 1'b0;
		fault_count  = 0;
		ticks_sent   = 0;
		leds_checked = 0;
		reg_writes   = 0;
		breath_turns = 0;
		dot_steps    = 0;
		seg_first[0] = SEG0_FIRST_RST;
		seg_count[0] = SEG0_COUNT_RST;
		seg_first[1] = SEG1_FIRST_RST;
		seg_count[1] = SEG1_COUNT_RST;
		for (int s = 0; s < 2; s++) begin
			dot_pos[s]    = 0;
			dot_ticks[s]  = 0;
			breath_lvl[s] = '0;
			breath_up[s]  = 1'b0;
			blink_lit[s]  = 1'b0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_layout();
		test_each_effect();
		test_layout_extremes();
		test_effect_runs(60);
		test_breath_sweep(300);
		test_full_rate(40);

		drain_engine();
		if (pending_leds.size() != 0) begin
			$display("%0d LED results never arrived", pending_leds.size());
			fault_count += pending_leds.size();
		end
		$display("Sent %0d effect ticks over %0d register writes; checked %0d LED results.",
			ticks_sent, reg_writes, leds_checked);
		$display("The dot advanced %0d times and breathing turned at the top %0d times.",
			dot_steps, breath_turns);
		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
